[src/tw_lru_pkg.sv]
// Shared constants and types for the two-way LRU tag directory.
package tw_lru_pkg;

	// Geometry. NUM_SETS must be a power of two.
	localparam int NUM_SETS    = 64;
	localparam int OFFSET_BITS = 5;
	localparam int ADDR_BITS   = 32;
	localparam int WAYS        = 2;

	localparam int SET_BITS   = $clog2(NUM_SETS);
	localparam int BLOCK_BITS = ADDR_BITS - OFFSET_BITS;
	localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;

	// Directory word: {lru, tag of way 1, tag of way 0}
	localparam int WORD_BITS = WAYS * TAG_BITS + 1;
	localparam int LRU_POS   = WAYS * TAG_BITS;

	// Fixed port widths
	localparam int ADDR_W    = 32;
	localparam int OFFSET_W  = 5;
	localparam int BLOCK_W   = 27;
	localparam int SET_W     = 6;
	localparam int TAG_W     = 21;
	localparam int COUNT_W   = 32;

	typedef struct packed {
		logic                way;
		logic                miss;
		logic                repl;
		logic [TAG_BITS-1:0] evicted;
		logic [COUNT_W-1:0]  hits;
		logic [COUNT_W-1:0]  misses;
	} lookup_t;

endpackage

[src/tw_lru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tw_lru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/tw_lru_meta.sv]
// Valid bits, hit/miss decision, replacement choice and running counters.
module tw_lru_meta (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                commit,
	input  logic [tw_lru_pkg::SET_BITS-1:0]     set_idx,
	input  logic [tw_lru_pkg::TAG_BITS-1:0]     tag,
	input  logic [tw_lru_pkg::WORD_BITS-1:0]    rd_word,
	output logic [tw_lru_pkg::WORD_BITS-1:0]    wr_word,
	output tw_lru_pkg::lookup_t                 res
);

	localparam int TB = tw_lru_pkg::TAG_BITS;

	logic [tw_lru_pkg::WAYS-1:0]    valid_q [tw_lru_pkg::NUM_SETS];
	logic [tw_lru_pkg::COUNT_W-1:0] hit_cnt_q;
	logic [tw_lru_pkg::COUNT_W-1:0] miss_cnt_q;

	logic [TB-1:0] tag0;
	logic [TB-1:0] tag1;
	logic          lru;
	logic [1:0]    vld;
	logic          hit0;
	logic          hit1;
	logic          hit;
	logic          way;
	logic [TB-1:0] new0;
	logic [TB-1:0] new1;

	assign tag0 = rd_word[TB-1:0];
	assign tag1 = rd_word[2*TB-1:TB];
	assign lru  = rd_word[tw_lru_pkg::LRU_POS];
	assign vld  = valid_q[set_idx];
	assign hit0 = vld[0] && (tag0 == tag);
	assign hit1 = vld[1] && (tag1 == tag);
	assign hit  = hit0 || hit1;

	always_comb begin
		if (hit) begin
			way = !hit0;
		end else if (!vld[0]) begin
			way = 1'b0;
		end else if (!vld[1]) begin
			way = 1'b1;
		end else begin
			way = lru;
		end
	end

	always_comb begin
		res.way     = way;
		res.miss    = !hit;
		res.repl    = !hit && vld[0] && vld[1];
		res.evicted = res.repl ? (way ? tag1 : tag0) : '0;
		res.hits    = hit_cnt_q + tw_lru_pkg::COUNT_W'(hit);
		res.misses  = miss_cnt_q + tw_lru_pkg::COUNT_W'(!hit);
	end

	// Refill the chosen way on a miss, keep both tags on a hit.
	assign new0    = (!hit && !way) ? tag : tag0;
	assign new1    = (!hit && way) ? tag : tag1;
	assign wr_word = {!way, new1, new0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tw_lru_pkg::NUM_SETS; i++) begin
				valid_q[i] <= '0;
			end
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (commit) begin
			if (!hit) begin
				valid_q[set_idx][way] <= 1'b1;
			end
			hit_cnt_q  <= res.hits;
			miss_cnt_q <= res.misses;
		end
	end

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (hit_cnt_q + miss_cnt_q) ==
			tw_lru_pkg::COUNT_W'($past(hit_cnt_q + miss_cnt_q) + 1'b1))
		else $error("hit plus miss count did not advance by one");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_q[$past(set_idx)][$past(way)])
		else $error("used way not valid after commit");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !res.miss |-> !res.repl && res.evicted == '0)
		else $error("eviction reported on a hit");

endmodule

[src/two_way_lru_cache_lookup_core.sv]
// Top level of the two-way set-associative LRU tag directory.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    address
//   out       source     out_valid/out_ready  byte_offset .. misses_so_far
//
// The accept edge issues the directory RAM read for the set; a later
// commit edge decides hit or miss, writes the set back and loads the
// output register, once that register is empty or being drained.
// Reset clears valid bits and counters at once; tag RAM contents need no
// clearing, since a tag is used only behind a set valid bit.
// A result waiting in the output register does not block the next accept;
// the decision stage holds only if the output register is still full.
module two_way_lru_cache_lookup_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tw_lru_pkg::ADDR_W-1:0]   address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tw_lru_pkg::OFFSET_W-1:0] byte_offset,
	output logic [tw_lru_pkg::BLOCK_W-1:0]  block_number,
	output logic [tw_lru_pkg::SET_W-1:0]    set_index,
	output logic                            way_used,
	output logic [tw_lru_pkg::TAG_W-1:0]    tag_value,
	output logic                            is_miss,
	output logic                            did_replace,
	output logic [tw_lru_pkg::TAG_W-1:0]    evicted_tag,
	output logic [tw_lru_pkg::COUNT_W-1:0]  hits_so_far,
	output logic [tw_lru_pkg::COUNT_W-1:0]  misses_so_far
);

	// Drop address bits above the modeled address width.
	logic [tw_lru_pkg::ADDR_BITS-1:0]  addr_in;
	logic [tw_lru_pkg::SET_BITS-1:0]   set_in;

	// Stage 1: transaction waiting on RAM data
	logic                              busy_s1;
	logic [tw_lru_pkg::ADDR_BITS-1:0]  addr_s1;
	logic [tw_lru_pkg::BLOCK_BITS-1:0] block_s1;
	logic [tw_lru_pkg::SET_BITS-1:0]   set_s1;
	logic [tw_lru_pkg::TAG_BITS-1:0]   tag_s1;

	logic                              accept;
	logic                              commit;
	logic [tw_lru_pkg::WORD_BITS-1:0]  rd_word;
	logic [tw_lru_pkg::WORD_BITS-1:0]  wr_word;
	tw_lru_pkg::lookup_t               res;

	// Output register
	logic                              out_valid_q;
	logic [tw_lru_pkg::OFFSET_W-1:0]   offset_q;
	logic [tw_lru_pkg::BLOCK_W-1:0]    block_q;
	logic [tw_lru_pkg::SET_W-1:0]      set_q;
	logic                              way_q;
	logic [tw_lru_pkg::TAG_W-1:0]      tag_q;
	logic                              miss_q;
	logic                              repl_q;
	logic [tw_lru_pkg::TAG_W-1:0]      evicted_q;
	logic [tw_lru_pkg::COUNT_W-1:0]    hits_q;
	logic [tw_lru_pkg::COUNT_W-1:0]    misses_q;

	assign addr_in  = tw_lru_pkg::ADDR_BITS'(address);
	assign set_in   = addr_in[tw_lru_pkg::OFFSET_BITS +: tw_lru_pkg::SET_BITS];

	assign in_ready = !busy_s1;
	assign accept   = in_valid && in_ready;
	// Advance the decision only when the output register can take it.
	assign commit   = busy_s1 && (!out_valid_q || out_ready);

	assign block_s1 = addr_s1[tw_lru_pkg::ADDR_BITS-1:tw_lru_pkg::OFFSET_BITS];
	assign set_s1   = block_s1[tw_lru_pkg::SET_BITS-1:0];
	assign tag_s1   = block_s1[tw_lru_pkg::BLOCK_BITS-1:tw_lru_pkg::SET_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr_in;
		end
	end

	// Directory RAM: both tags and the LRU bit of one set per word.
	// Read data holds while the decision stalls, since no new read is issued.
	tw_lru_ram #(
		.WIDTH (tw_lru_pkg::WORD_BITS),
		.DEPTH (tw_lru_pkg::NUM_SETS)
	) u_dir_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (set_s1),
		.wdata (wr_word),
		.re    (accept),
		.raddr (set_in),
		.rdata (rd_word)
	);

	tw_lru_meta u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.set_idx (set_s1),
		.tag     (tag_s1),
		.rd_word (rd_word),
		.wr_word (wr_word),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result fields, sized to the port widths.
	always_ff @(posedge clk) begin
		if (commit) begin
			offset_q  <= tw_lru_pkg::OFFSET_W'(addr_s1[tw_lru_pkg::OFFSET_BITS-1:0]);
			block_q   <= tw_lru_pkg::BLOCK_W'(block_s1);
			set_q     <= tw_lru_pkg::SET_W'(set_s1);
			way_q     <= res.way;
			tag_q     <= tw_lru_pkg::TAG_W'(tag_s1);
			miss_q    <= res.miss;
			repl_q    <= res.repl;
			evicted_q <= tw_lru_pkg::TAG_W'(res.evicted);
			hits_q    <= res.hits;
			misses_q  <= res.misses;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_offset   = offset_q;
	assign block_number  = block_q;
	assign set_index     = set_q;
	assign way_used      = way_q;
	assign tag_value     = tag_q;
	assign is_miss       = miss_q;
	assign did_replace   = repl_q;
	assign evicted_tag   = evicted_q;
	assign hits_so_far   = hits_q;
	assign misses_so_far = misses_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_s1)
		else $error("accepted transaction not held in stage 1");

	a_repl_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && repl_q |-> miss_q)
		else $error("replacement reported on a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !repl_q |-> evicted_q == '0)
		else $error("evicted tag nonzero without replacement");

	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && !busy_s1)
		else $error("commit did not load the output register");

endmodule
